// ===== rtl/rps_pkg.sv =====
`default_nettype none

package rps_pkg;

  // default sizes
  localparam int MAX_PHASES_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // opcodes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;
  localparam logic [2:0] OP_NEXT   = 3'd5;
  localparam logic [2:0] OP_LOAD   = 3'd6;

  // run status
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_PAUSE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // phase end kinds
  localparam logic [2:0] KIND_DURATION  = 3'd0;
  localparam logic [2:0] KIND_REFERENCE = 3'd2;
  localparam logic [2:0] KIND_FIRST     = 3'd3;
  localparam logic [2:0] KIND_ALL       = 3'd4;

  // advance reasons
  localparam logic [2:0] REASON_NONE     = 3'd0;
  localparam logic [2:0] REASON_MANUAL   = 3'd1;
  localparam logic [2:0] REASON_DURATION = 3'd2;
  localparam logic [2:0] REASON_TARGET   = 3'd3;
  localparam logic [2:0] REASON_CAP      = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_seconds;
    logic        ref_piece;
    logic        reference_reached;
    logic        any_reached;
    logic        all_reached;
    logic [3:0]  slot;
    logic [2:0]  end_kind;
    logic [31:0] duration_seconds;
    logic [31:0] cap_seconds;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  current_phase;
    logic        advanced;
    logic        programme_done;
    logic [2:0]  advance_reason;
    logic [1:0]  run_status;
    logic [31:0] seconds_left;
  } out_item_t;

  // per-request outcome of the execute stage
  typedef struct packed {
    logic       advanced;
    logic       programme_done;
    logic [2:0] advance_reason;
  } step_flags_t;

  typedef struct packed {
    logic [2:0]  end_kind;
    logic [31:0] duration;
    logic [31:0] cap;
  } table_entry_t;

endpackage

`default_nettype wire

// ===== rtl/rps_table.sv =====
`default_nettype none

module rps_table #(
  parameter int DEPTH  = rps_pkg::MAX_PHASES_DEF,
  parameter int ADDR_W = $clog2(rps_pkg::MAX_PHASES_DEF)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ADDR_W-1:0]     waddr,
  input  wire rps_pkg::table_entry_t wdata,
  input  wire logic [ADDR_W-1:0]     raddr,
  output rps_pkg::table_entry_t      rdata
);
  import rps_pkg::*;

  table_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, write-first on the same address
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rps_core.sv =====
`default_nettype none

module rps_core #(
  parameter int MAX_PHASES = rps_pkg::MAX_PHASES_DEF,
  parameter int TIME_BITS  = rps_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [4:0]           cfg_data,
  input  wire logic                 exec_en,
  input  wire rps_pkg::in_item_t    item,
  output rps_pkg::step_flags_t      flags,
  input  wire logic [31:0]          fin_now,
  input  wire rps_pkg::step_flags_t fin_flags,
  output rps_pkg::out_item_t        result
);
  import rps_pkg::*;

  localparam int PTR_W = $clog2(MAX_PHASES);
  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [1:0]           status, status_next;
  logic [PTR_W-1:0]     ptr, ptr_next;
  logic [TIME_BITS-1:0] start_t, start_t_next;
  logic [TIME_BITS-1:0] pause_t, pause_t_next;
  logic                 manual, manual_next;
  logic [4:0]           num_phases;

  table_entry_t cur;
  table_entry_t wentry;
  logic         twe;

  logic [TIME_BITS-1:0] now_t, el;
  logic [CMP_W-1:0]     el_c, dur_c, cap_c;
  logic [31:0]          ptr_ext, ptr_inc;
  logic                 has_phase, is_last, kind_hit, dur_hit;
  logic [2:0]           reason;

  rps_table #(
    .DEPTH  (MAX_PHASES),
    .ADDR_W (PTR_W)
  ) u_table (
    .clk   (clk),
    .we    (twe),
    .waddr (PTR_W'(item.slot)),
    .wdata (wentry),
    .raddr (ptr_next),
    .rdata (cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_phases <= 5'd1;
    end else if (cfg_we) begin
      num_phases <= cfg_data;
    end
  end

  // shared view of the current phase
  assign ptr_ext   = 32'(ptr);
  assign ptr_inc   = ptr_ext + 32'd1;
  assign has_phase = (status != ST_IDLE) && (ptr_ext < 32'(num_phases));
  assign is_last   = !((ptr_inc < 32'(num_phases)) && (ptr_inc < 32'(MAX_PHASES)));
  assign dur_c     = CMP_W'(cur.duration);
  assign cap_c     = CMP_W'(cur.cap);

  // end check for a tick
  assign now_t = TIME_BITS'(item.now_seconds);
  assign el    = now_t - start_t;
  assign el_c  = CMP_W'(el);
  assign dur_hit = (el_c >= dur_c);

  always_comb begin
    case (cur.end_kind)
      KIND_DURATION:  kind_hit = dur_hit;
      KIND_REFERENCE: kind_hit = item.ref_piece && item.reference_reached;
      KIND_FIRST:     kind_hit = item.any_reached;
      KIND_ALL:       kind_hit = item.all_reached;
      default:        kind_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (!has_phase) begin
      reason = REASON_NONE;
    end else if (manual) begin
      reason = REASON_MANUAL;
    end else if (kind_hit) begin
      reason = (cur.end_kind == KIND_DURATION) ? REASON_DURATION : REASON_TARGET;
    end else if ((cap_c != '0) && (el_c >= cap_c)) begin
      reason = REASON_CAP;
    end else begin
      reason = REASON_NONE;
    end
  end

  always_comb begin
    status_next  = status;
    ptr_next     = ptr;
    start_t_next = start_t;
    pause_t_next = pause_t;
    manual_next  = manual;
    flags        = '0;
    twe          = 1'b0;
    wentry.end_kind = item.end_kind;
    wentry.duration = item.duration_seconds;
    wentry.cap      = item.cap_seconds;
    if (exec_en) begin
      unique case (item.opcode)
        OP_TICK: begin
          if ((status == ST_RUN) && (reason != REASON_NONE)) begin
            flags.advance_reason = reason;
            manual_next = 1'b0;
            if (!is_last) begin
              ptr_next       = ptr + PTR_W'(1);
              start_t_next   = now_t;
              flags.advanced = 1'b1;
            end else begin
              status_next          = ST_DONE;
              flags.programme_done = 1'b1;
            end
          end
        end
        OP_START: begin
          ptr_next     = '0;
          start_t_next = now_t;
          manual_next  = 1'b0;
          status_next  = ST_RUN;
        end
        OP_STOP: begin
          status_next = ST_IDLE;
          manual_next = 1'b0;
        end
        OP_PAUSE: begin
          if (status == ST_RUN) begin
            pause_t_next = now_t;
            status_next  = ST_PAUSE;
          end
        end
        OP_RESUME: begin
          if (status == ST_PAUSE) begin
            start_t_next = start_t + now_t - pause_t;
            status_next  = ST_RUN;
          end
        end
        OP_NEXT: begin
          manual_next = 1'b1;
        end
        OP_LOAD: begin
          twe = (32'(item.slot) < 32'(MAX_PHASES));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status  <= ST_IDLE;
      ptr     <= '0;
      start_t <= '0;
      pause_t <= '0;
      manual  <= 1'b0;
    end else begin
      status  <= status_next;
      ptr     <= ptr_next;
      start_t <= start_t_next;
      pause_t <= pause_t_next;
      manual  <= manual_next;
    end
  end

  // time to deadline from the state left by the finishing request
  logic [TIME_BITS-1:0] fin_el;
  logic [CMP_W-1:0]     fin_el_c, dl;
  logic [31:0]          left;

  assign fin_el   = TIME_BITS'(fin_now) - start_t;
  assign fin_el_c = CMP_W'(fin_el);

  always_comb begin
    if (cur.end_kind == KIND_DURATION) begin
      dl = dur_c;
    end else begin
      dl = cap_c;
    end
    if (!has_phase || (status != ST_RUN) || (dl == '0) || (dl <= fin_el_c)) begin
      left = '0;
    end else begin
      left = 32'(dl - fin_el_c);
    end
  end

  always_comb begin
    result.current_phase  = 4'(ptr);
    result.advanced       = fin_flags.advanced;
    result.programme_done = fin_flags.programme_done;
    result.advance_reason = fin_flags.advance_reason;
    result.run_status     = status;
    result.seconds_left   = left;
  end

endmodule

`default_nettype wire

// ===== rtl/recipe_phase_sequencer.sv =====
// recipe phase sequencer: runs a programme of up to MAX_PHASES phases from a
// phase table. every request carries an opcode (tick, start, stop, pause,
// resume, request next, load phase) and returns exactly one result with the
// phase pointer, the run status, whether this tick moved on or finished the
// programme and why, and the seconds left to the phase deadline. times are
// whole seconds that wrap modulo 2^TIME_BITS. the block takes one request per
// cycle while the result side does not stall; a request passes the input
// register, the execute stage and the result register in that order, and
// item_ready follows result_ready combinationally. while a result waits, up
// to two more requests are taken before item_ready drops. the phase count is
// written on the cfg channel (always ready) and must only be changed while no
// request is in flight. table entries are undefined until loaded.
`default_nettype none

module recipe_phase_sequencer #(
  parameter int MAX_PHASES = rps_pkg::MAX_PHASES_DEF,
  parameter int TIME_BITS  = rps_pkg::TIME_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire rps_pkg::in_item_t item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output rps_pkg::out_item_t     result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [4:0]        cfg_data
);
  import rps_pkg::*;

  // stage 1: input register
  logic     s1_valid;
  in_item_t s1_item;

  // stage 2: request executed, state already updated; finish pending
  logic        s2_valid;
  logic [31:0] s2_now;
  step_flags_t s2_flags;

  step_flags_t exec_flags;
  out_item_t   fin_result;

  logic out_load, s2_free, exec_en, s1_free;

  // each stage moves when the one after it has room
  assign out_load   = s2_valid && (!result_valid || result_ready);
  assign s2_free    = !s2_valid || out_load;
  assign exec_en    = s1_valid && s2_free;
  assign s1_free    = !s1_valid || exec_en;
  assign item_ready = s1_free;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && s1_free) begin
      s1_item <= item;
    end
  end

  // the core reads the registered state when it finishes the stage-2 request;
  // no later request can have changed that state, since a request only
  // executes in the cycle its predecessor leaves stage 2 or later
  rps_core #(
    .MAX_PHASES (MAX_PHASES),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .exec_en   (exec_en),
    .item      (s1_item),
    .flags     (exec_flags),
    .fin_now   (s2_now),
    .fin_flags (s2_flags),
    .result    (fin_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= exec_en;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      s2_now   <= s1_item.now_seconds;
      s2_flags <= exec_flags;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= fin_result;
    end
  end

endmodule

`default_nettype wire
